// ----- hw/rtl/m7sa_pkg.sv -----
`default_nettype none
package m7sa_pkg;
    localparam int LineW = 9;
    localparam int DivW  = 32;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        REG_CAMERA_X      = 3'd0,
        REG_CAMERA_HEIGHT = 3'd1,
        REG_CAMERA_Z      = 3'd2,
        REG_ROT_COS       = 3'd3,
        REG_ROT_SIN       = 3'd4,
        REG_PROJ_DIST     = 3'd5
    } reg_idx_t;

    // Work item handed from front to back: magnitude of the dividend, divisor, sign
    typedef struct packed {
        logic [DivW-1:0]  mag;
        logic [LineW:0]   den;
        logic             neg;
    } div_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/mode7_scanline_affine_top.sv -----
// Per-scanline perspective floor affine parameters. Each scanline request
// yields scale_a, scale_c, offset_x and offset_y. Each item is taken from
// the queue, then passes through a bit-serial divider, two multiply
// stages, a sum stage and the output register. The next item starts only
// once the result has been taken. A two-entry queue in front accepts
// further requests while one is in work.
`default_nettype none
module mode7_scanline_affine_top
    import m7sa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [LineW-1:0]  scanline,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            scale_a,
    output logic [15:0]            scale_c,
    output logic [31:0]            offset_x,
    output logic [31:0]            offset_y,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    logic [31:0] cam_x_reg, cam_h_reg, cam_z_reg;
    logic [9:0]  cos_reg, sin_reg;
    logic [15:0] dist_reg;
    logic        q_valid, q_pop;
    div_req_t    q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_h_reg <= '0;
            cam_z_reg <= '0;
            cos_reg   <= 10'd256;
            sin_reg   <= '0;
            dist_reg  <= 16'd160;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAMERA_X:      cam_x_reg <= cfg_data;
                REG_CAMERA_HEIGHT: cam_h_reg <= cfg_data;
                REG_CAMERA_Z:      cam_z_reg <= cfg_data;
                REG_ROT_COS:       cos_reg   <= cfg_data[9:0];
                REG_ROT_SIN:       sin_reg   <= cfg_data[9:0];
                REG_PROJ_DIST:     dist_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    m7sa_front u_front (
        .clk, .rst_n,
        .valid(in_valid), .stall(in_stall), .scanline,
        .camera_height(cam_h_reg),
        .q_valid, .q_pop, .q_head
    );

    m7sa_back u_back (
        .clk, .rst_n,
        .q_valid, .q_pop, .q_head,
        .camera_x(cam_x_reg), .camera_z(cam_z_reg),
        .rotation_cosine(cos_reg), .rotation_sine(sin_reg),
        .projection_distance(dist_reg),
        .valid(out_valid), .stall(out_stall),
        .scale_a, .scale_c, .offset_x, .offset_y
    );
endmodule
`default_nettype wire

// ----- hw/rtl/m7sa_front.sv -----
`default_nettype none
module m7sa_front
    import m7sa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    output logic                   stall,
    input  wire logic [LineW-1:0]  scanline,
    input  wire logic [31:0]       camera_height,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output div_req_t               q_head
);
    div_req_t                    mem_reg [QDepth];
    logic [$clog2(QDepth)-1:0]   wp_reg, rp_reg;
    logic [$clog2(QDepth):0]     cnt_reg;
    logic [31:0]                 num;
    div_req_t                    req;
    logic                        push;

    always_comb
    begin
        num      = camera_height << 4;
        req.neg  = num[31];
        req.mag  = num[31] ? (32'd0 - num) : num;
        req.den  = {1'b0, scanline} + {{LineW{1'b0}}, 1'b1};
    end

    assign stall   = (cnt_reg == ($clog2(QDepth)+1)'(QDepth));
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/m7sa_back.sv -----
`default_nettype none
module m7sa_back
    import m7sa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire div_req_t    q_head,
    input  wire logic [31:0] camera_x,
    input  wire logic [31:0] camera_z,
    input  wire logic [9:0]  rotation_cosine,
    input  wire logic [9:0]  rotation_sine,
    input  wire logic [15:0] projection_distance,
    output logic             valid,
    input  wire logic        stall,
    output logic [15:0]      scale_a,
    output logic [15:0]      scale_c,
    output logic [31:0]      offset_x,
    output logic [31:0]      offset_y
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_SUM  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t       st_reg, st_next;
    logic [31:0]  rem_reg, quo_reg;
    logic [LineW:0] den_reg;
    logic         neg_reg;
    logic [4:0]   bit_reg;
    logic [31:0]  wcc_reg, wss_reg, pdc_reg, pds_reg;
    logic [31:0]  ww;
    logic [32:0]  trial;
    logic [31:0]  rem_sh;
    logic [31:0]  dist32;
    logic [24:0]  pa, pc;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {23'd0, den_reg};
    assign ww     = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign dist32 = {{16{projection_distance[15]}}, projection_distance};
    assign pa     = wcc_reg[31:7];
    assign pc     = wss_reg[31:7];
    assign q_pop  = (st_reg == S_IDLE) && q_valid;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (q_valid) st_next = S_DIV;
            S_DIV:  if (bit_reg == 5'd31) st_next = S_MUL1;
            S_MUL1: st_next = S_MUL2;
            S_MUL2: st_next = S_SUM;
            S_SUM:  st_next = S_OUT;
            S_OUT:  if (!valid || !stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            valid  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (valid && !stall)
                valid <= 1'b0;
            if (st_reg == S_SUM)
                valid <= 1'b1;
        end
    end

    logic [31:0] pwc, pws;
    assign pwc = $signed(ww) * $signed({{22{rotation_cosine[9]}}, rotation_cosine});
    assign pws = $signed(ww) * $signed({{22{rotation_sine[9]}}, rotation_sine});

    logic [31:0] pdc, pds;
    assign pdc = $signed(dist32) * $signed(wcc_reg);
    assign pds = $signed(dist32) * $signed(wss_reg);

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                quo_reg <= q_head.mag;
                rem_reg <= '0;
                den_reg <= q_head.den;
                neg_reg <= q_head.neg;
                bit_reg <= '0;
            end
            S_DIV:
            begin
                bit_reg <= bit_reg + 5'd1;
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            S_MUL1:
            begin
                wcc_reg <= {{5{pwc[31]}}, pwc[31:5]};
                wss_reg <= {{5{pws[31]}}, pws[31:5]};
            end
            S_MUL2:
            begin
                pdc_reg <= pdc;
                pds_reg <= pds;
            end
            S_SUM:
            begin
                scale_a  <= pa[15:0];
                scale_c  <= pc[15:0];
                offset_x <= camera_x - {pa, 7'd0}
                            + {{7{pds_reg[31]}}, pds_reg[31:7]};
                offset_y <= camera_z - {pc, 7'd0}
                            - {{7{pdc_reg[31]}}, pdc_reg[31:7]};
            end
            S_OUT: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
